### design/lea128d_pkg.sv
// ----------------------------------------------------------------------------
// LEA-128 decryption package
// Shared widths, payload types and the controller state type for the block
// decryption core and its round datapath.
// ----------------------------------------------------------------------------
package lea128d_pkg;

  // Default round count and word geometry
  localparam int unsigned RoundsDef     = 24;
  localparam int unsigned WordW         = 32;
  localparam int unsigned WordsPerRound = 4;
  localparam int unsigned KeyIdxW       = 7;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 128;

  // Rotation amounts of the inverse round
  localparam int unsigned RorX0 = 9;
  localparam int unsigned RolX1 = 5;
  localparam int unsigned RolX2 = 3;

  typedef logic [WordW-1:0] word_t;

  // Four words: either one round-key row (k0, shared k1, k2, k3) or a block
  typedef word_t [WordsPerRound-1:0] quad_t;

  // Input kind carried on tuser
  typedef enum logic {
    OP_KEY_WRITE = 1'b0,
    OP_DECRYPT   = 1'b1
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

### design/lea128d_round.sv
// ----------------------------------------------------------------------------
// LEA-128 inverse round
// One decryption round: the words rotate by one place, then three chained
// rotate/subtract/xor steps undo the forward round using one key row.
// ----------------------------------------------------------------------------
module lea128d_round (
  input  lea128d_pkg::quad_t blk_i,
  input  lea128d_pkg::quad_t key_i,
  output lea128d_pkg::quad_t blk_o
);

  lea128d_pkg::word_t rot0;
  lea128d_pkg::word_t rot1;
  lea128d_pkg::word_t rot2;

  // Fixed rotations of the incoming words
  assign rot0 = (blk_i[0] >> lea128d_pkg::RorX0) |
                (blk_i[0] << (lea128d_pkg::WordW - lea128d_pkg::RorX0));
  assign rot1 = (blk_i[1] << lea128d_pkg::RolX1) |
                (blk_i[1] >> (lea128d_pkg::WordW - lea128d_pkg::RolX1));
  assign rot2 = (blk_i[2] << lea128d_pkg::RolX2) |
                (blk_i[2] >> (lea128d_pkg::WordW - lea128d_pkg::RolX2));

  // Word roles move by one; each new word feeds the next subtraction
  always_comb begin
    blk_o[0] = blk_i[3];
    blk_o[1] = (rot0 - (blk_o[0] ^ key_i[0])) ^ key_i[1];
    blk_o[2] = (rot1 - (blk_o[1] ^ key_i[2])) ^ key_i[1];
    blk_o[3] = (rot2 - (blk_o[2] ^ key_i[3])) ^ key_i[1];
  end

endmodule

### design/lea128_block_decrypt_top.sv
// ----------------------------------------------------------------------------
// LEA-128 block decryption core
// Usage:
//   Slave stream carries one item per transfer. tuser selects the operation:
//   0 writes key_word into the round-key memory at key_index (round*4+word),
//   1 decrypts the four ciphertext words in tdata. Key writes give no result;
//   writes at an index of Rounds*4 or above are dropped. All key words must be
//   loaded before the first decryption.
//   Master stream carries one plaintext block per decryption.
// Timing:
//   A decryption runs Rounds rounds, one round per cycle, the last round
//   holding while the output register is still full; the round-key row is
//   read from the key memory in the cycle before its use. The result is
//   registered with the last round. A new block is taken only after the last
//   one has finished; tready is low while a block is in flight.
//   A finished result waits in the output register; a new item is taken while
//   it waits. If the receiver still stalls when the next block finishes, the
//   last round holds until the output register frees.
// Reset: clears the controller and the output valid; key memory contents are
//   not cleared and must be rewritten.
// ----------------------------------------------------------------------------
module lea128_block_decrypt_top #(
  parameter int unsigned Rounds = lea128d_pkg::RoundsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [6:0] key_index, [38:7] key_word, [70:39] block_word_0,
  // [102:71] block_word_1, [134:103] block_word_2, [166:135] block_word_3
  input  logic [lea128d_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] op
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [31:0] plain_word_0, [63:32] plain_word_1, [95:64] plain_word_2,
  // [127:96] plain_word_3
  output logic [lea128d_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam int unsigned RowW       = (Rounds > 1) ? $clog2(Rounds) : 1;
  localparam int unsigned StoreDepth = Rounds * lea128d_pkg::WordsPerRound;
  localparam int unsigned IdxCmpW    = lea128d_pkg::KeyIdxW + 1;
  localparam int unsigned ColW       = $clog2(lea128d_pkg::WordsPerRound);
  localparam int unsigned WordW      = lea128d_pkg::WordW;

  // Input field unpacking
  logic [lea128d_pkg::KeyIdxW-1:0] key_index;
  lea128d_pkg::word_t              key_word;
  lea128d_pkg::quad_t              in_blk;

  assign key_index = s_axis_tdata_i[lea128d_pkg::KeyIdxW-1:0];
  assign key_word  = s_axis_tdata_i[lea128d_pkg::KeyIdxW +: WordW];
  always_comb begin
    for (int j = 0; j < lea128d_pkg::WordsPerRound; j++) begin
      in_blk[j] = s_axis_tdata_i[lea128d_pkg::KeyIdxW + WordW*(j+1) +: WordW];
    end
  end

  // Control signals
  lea128d_pkg::state_e state_q, state_d;
  logic [RowW-1:0]     round_q, round_d;
  logic [RowW-1:0]     rd_row;
  logic                s_fire;
  logic                start;
  logic                key_we;
  logic                last_round;
  logic                out_free;
  logic                step_en;
  logic                finish;
  logic                m_valid_q, m_valid_d;

  lea128d_pkg::quad_t  blk_q, blk_d;
  lea128d_pkg::quad_t  round_out;
  lea128d_pkg::quad_t  key_rd_q;
  lea128d_pkg::quad_t  m_data_q;

  assign s_axis_tready_o = (state_q == lea128d_pkg::ST_IDLE);
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign start      = s_fire && (lea128d_pkg::op_e'(s_axis_tuser_i) == lea128d_pkg::OP_DECRYPT);
  assign key_we     = s_fire && (lea128d_pkg::op_e'(s_axis_tuser_i) == lea128d_pkg::OP_KEY_WRITE)
                      && ({1'b0, key_index} < IdxCmpW'(StoreDepth));
  assign last_round = (round_q == '0);
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign step_en    = (state_q == lea128d_pkg::ST_RUN) && (!last_round || out_free);
  assign finish     = (state_q == lea128d_pkg::ST_RUN) && last_round && out_free;

  // Key row for the next cycle: re-read the current row while stalled
  always_comb begin
    if (start) begin
      rd_row = RowW'(Rounds - 1);
    end else if (step_en) begin
      rd_row = round_q - 1'b1;
    end else begin
      rd_row = round_q;
    end
  end

  // Round-key memory: one word written, one full row read per cycle
  lea128d_pkg::quad_t key_mem [Rounds];

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_index[ColW +: RowW]][key_index[ColW-1:0]] <= key_word;
    end
    key_rd_q <= key_mem[rd_row];
  end

  // Round datapath
  lea128d_round u_round (
    .blk_i (blk_q),
    .key_i (key_rd_q),
    .blk_o (round_out)
  );

  // Next state, round counter and working block
  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    blk_d     = blk_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      lea128d_pkg::ST_IDLE: begin
        if (start) begin
          state_d = lea128d_pkg::ST_RUN;
          round_d = RowW'(Rounds - 1);
          blk_d   = in_blk;
        end
      end
      lea128d_pkg::ST_RUN: begin
        if (step_en) begin
          round_d = round_q - 1'b1;
          blk_d   = round_out;
        end
        if (finish) begin
          state_d   = lea128d_pkg::ST_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = lea128d_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lea128d_pkg::ST_IDLE;
      round_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      round_q   <= round_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (finish) begin
      m_data_q <= round_out;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // A decrypt transfer starts the run at the last round
  a_start_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == lea128d_pkg::ST_RUN) && (round_q == RowW'(Rounds - 1)))
    else $error("decryption did not start at the last round");

  // A new result only follows the final round
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(finish))
    else $error("result raised without finishing the rounds");

  // The round counter only moves down by one while running
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && !last_round |=> round_q == $past(round_q) - 1'b1)
    else $error("round counter skipped");
`endif

endmodule
